[rtl/core/bde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce and encoder decode package
// Shared flag codes, types and defaults for the debouncer and its top level.
// ----------------------------------------------------------------------------
package bde_pkg;

   // Default number of agreeing samples that make a pin stable.
   localparam int DEBOUNCE_LEN_DEFAULT = 6;

   typedef logic [1:0] flag_type;

   localparam flag_type FLAG_READY   = 2'd0;
   localparam flag_type FLAG_SET     = 2'd1;
   localparam flag_type FLAG_CLEARED = 2'd2;

   // Debounced view of one pin after the newest sample has been shifted in.
   typedef struct packed {
      logic stable_low;
      logic stable_high;
   } stable_type;

endpackage

[rtl/core/button_debounce_encoder_decode_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce and encoder decode, top level
// Debounces five active-low pins per poll word and keeps six event flags
// (advance, cancel, next, previous, power off, power on) with consumer clears.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Contents
//  req_      in         req_valid / req_ready  five pin samples, six clears
//  rsp_      out        rsp_valid / rsp_ready  six 2-bit flags, power level
//
// Each accepted request word produces exactly one response word, registered
// in the cycle after acceptance. A new request word can be accepted every
// cycle unless a response is stalled; the state update that sets the rate
// completes the history shift and the flag logic between the state registers.
// The request side is ready whenever the response register is empty or is
// being drained in the same cycle, so a stalled response holds back only one
// word. Reset is synchronous and clears the histories to all zeros (which
// read as stable low), the flags to ready and the encoder levels to low.
//
module button_debounce_encoder_decode_top #(
   parameter int DEBOUNCE_LEN = bde_pkg::DEBOUNCE_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_advance_pin,
   input  logic              req_cancel_pin,
   input  logic              req_power_pin,
   input  logic              req_enc_a_pin,
   input  logic              req_enc_b_pin,
   input  logic              req_clear_advance,
   input  logic              req_clear_cancel,
   input  logic              req_clear_next,
   input  logic              req_clear_previous,
   input  logic              req_clear_power_off,
   input  logic              req_clear_power_on,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bde_pkg::flag_type rsp_advance_status,
   output bde_pkg::flag_type rsp_cancel_status,
   output bde_pkg::flag_type rsp_next_status,
   output bde_pkg::flag_type rsp_previous_status,
   output bde_pkg::flag_type rsp_power_off_status,
   output bde_pkg::flag_type rsp_power_on_status,
   output logic              rsp_power_level_low
);

   logic accept;

   // Debounced views of the pins, taken with this word's sample included.
   bde_pkg::stable_type adv_stable;
   bde_pkg::stable_type can_stable;
   bde_pkg::stable_type pwr_stable;
   bde_pkg::stable_type enc_a_stable;
   bde_pkg::stable_type enc_b_stable;

   // Flag state and the encoder's debounced levels.
   bde_pkg::flag_type adv_flag_ff,  adv_flag_in;
   bde_pkg::flag_type can_flag_ff,  can_flag_in;
   bde_pkg::flag_type next_flag_ff, next_flag_in;
   bde_pkg::flag_type prev_flag_ff, prev_flag_in;
   bde_pkg::flag_type off_flag_ff,  off_flag_in;
   bde_pkg::flag_type on_flag_ff,   on_flag_in;
   logic              enc_a_level_ff, enc_a_level_in;
   logic              enc_b_level_ff, enc_b_level_in;

   // Response register.
   logic              rsp_valid_ff;
   logic              power_low_ff;

   // The response register is free when empty or when it empties this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   bde_debounce #(.LEN(DEBOUNCE_LEN)) u_adv (
      .clock(clock), .reset(reset), .shift(accept),
      .sample(req_advance_pin), .stable(adv_stable)
   );

   bde_debounce #(.LEN(DEBOUNCE_LEN)) u_can (
      .clock(clock), .reset(reset), .shift(accept),
      .sample(req_cancel_pin), .stable(can_stable)
   );

   bde_debounce #(.LEN(DEBOUNCE_LEN)) u_pwr (
      .clock(clock), .reset(reset), .shift(accept),
      .sample(req_power_pin), .stable(pwr_stable)
   );

   bde_debounce #(.LEN(DEBOUNCE_LEN)) u_enc_a (
      .clock(clock), .reset(reset), .shift(accept),
      .sample(req_enc_a_pin), .stable(enc_a_stable)
   );

   bde_debounce #(.LEN(DEBOUNCE_LEN)) u_enc_b (
      .clock(clock), .reset(reset), .shift(accept),
      .sample(req_enc_b_pin), .stable(enc_b_stable)
   );

   // Flag update. A clear request takes effect first, so the pin logic below
   // works on the cleared value. A cleared button flag is not set again by a
   // press; only a stable release brings it back to ready.
   always_comb begin
      adv_flag_in    = req_clear_advance   ? bde_pkg::FLAG_CLEARED : adv_flag_ff;
      can_flag_in    = req_clear_cancel    ? bde_pkg::FLAG_CLEARED : can_flag_ff;
      next_flag_in   = req_clear_next      ? bde_pkg::FLAG_CLEARED : next_flag_ff;
      prev_flag_in   = req_clear_previous  ? bde_pkg::FLAG_CLEARED : prev_flag_ff;
      off_flag_in    = req_clear_power_off ? bde_pkg::FLAG_CLEARED : off_flag_ff;
      on_flag_in     = req_clear_power_on  ? bde_pkg::FLAG_CLEARED : on_flag_ff;
      enc_a_level_in = enc_a_level_ff;
      enc_b_level_in = enc_b_level_ff;

      if (adv_stable.stable_low && adv_flag_in == bde_pkg::FLAG_READY) begin
         adv_flag_in = bde_pkg::FLAG_SET;
      end else if (adv_stable.stable_high) begin
         adv_flag_in = bde_pkg::FLAG_READY;
      end

      if (can_stable.stable_low && can_flag_in == bde_pkg::FLAG_READY) begin
         can_flag_in = bde_pkg::FLAG_SET;
      end else if (can_stable.stable_high) begin
         can_flag_in = bde_pkg::FLAG_READY;
      end

      // The two power flags re-arm each other.
      if (pwr_stable.stable_low) begin
         if (off_flag_in == bde_pkg::FLAG_READY) begin
            off_flag_in = bde_pkg::FLAG_SET;
         end
         on_flag_in = bde_pkg::FLAG_READY;
      end else if (pwr_stable.stable_high) begin
         if (on_flag_in == bde_pkg::FLAG_READY) begin
            on_flag_in = bde_pkg::FLAG_SET;
         end
         off_flag_in = bde_pkg::FLAG_READY;
      end

      // A rising debounced edge on A picks its direction from B's level as it
      // stood before this word; B's level is updated afterwards.
      if (enc_a_stable.stable_low) begin
         enc_a_level_in = 1'b0;
      end else if (enc_a_stable.stable_high) begin
         if (!enc_a_level_ff) begin
            if (enc_b_level_ff) begin
               next_flag_in = bde_pkg::FLAG_SET;
            end else begin
               prev_flag_in = bde_pkg::FLAG_SET;
            end
         end
         enc_a_level_in = 1'b1;
      end

      if (enc_b_stable.stable_low) begin
         enc_b_level_in = 1'b0;
      end else if (enc_b_stable.stable_high) begin
         enc_b_level_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_flag_ff    <= bde_pkg::FLAG_READY;
         can_flag_ff    <= bde_pkg::FLAG_READY;
         next_flag_ff   <= bde_pkg::FLAG_READY;
         prev_flag_ff   <= bde_pkg::FLAG_READY;
         off_flag_ff    <= bde_pkg::FLAG_READY;
         on_flag_ff     <= bde_pkg::FLAG_READY;
         enc_a_level_ff <= 1'b0;
         enc_b_level_ff <= 1'b0;
      end else if (accept) begin
         adv_flag_ff    <= adv_flag_in;
         can_flag_ff    <= can_flag_in;
         next_flag_ff   <= next_flag_in;
         prev_flag_ff   <= prev_flag_in;
         off_flag_ff    <= off_flag_in;
         on_flag_ff     <= on_flag_in;
         enc_a_level_ff <= enc_a_level_in;
         enc_b_level_ff <= enc_b_level_in;
      end
   end

   // The flag registers double as the response payload; only the raw power
   // level needs a register of its own.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         power_low_ff <= !req_power_pin;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_advance_status   = adv_flag_ff;
   assign rsp_cancel_status    = can_flag_ff;
   assign rsp_next_status      = next_flag_ff;
   assign rsp_previous_status  = prev_flag_ff;
   assign rsp_power_off_status = off_flag_ff;
   assign rsp_power_on_status  = on_flag_ff;
   assign rsp_power_level_low  = power_low_ff;

   // Every accepted word shows up as a response in the next cycle.
   a_accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept) |=> rsp_valid)
      else $error("accepted word did not produce a response");

   // The power flags re-arm each other, so both can never be set at once.
   a_power_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(off_flag_ff == bde_pkg::FLAG_SET && on_flag_ff == bde_pkg::FLAG_SET))
      else $error("power off and power on flags both set");

   // A clear with a pressed sample cannot be undone by a release in that word.
   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept && req_clear_advance && !req_advance_pin)
      |=> rsp_advance_status == bde_pkg::FLAG_CLEARED)
      else $error("advance clear lost");

   // The power level reported belongs to the word just accepted.
   a_power_level: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept) |=> rsp_power_level_low == !$past(req_power_pin))
      else $error("power level does not match the accepted sample");

endmodule

[rtl/core/bde_debounce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pin debouncer
// Shift-register history of one pin, reporting whether the newest LEN
// samples are all low or all high.
// ----------------------------------------------------------------------------
module bde_debounce #(
   parameter int LEN = bde_pkg::DEBOUNCE_LEN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic                sample,
   output bde_pkg::stable_type stable
);

   logic [LEN-1:0] history_ff;
   logic [LEN-1:0] history_in;

   // The decision looks at the history including the sample being taken.
   assign history_in = {history_ff[LEN-2:0], sample};

   assign stable.stable_low  = (history_in == '0);
   assign stable.stable_high = (history_in == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else if (shift) begin
         history_ff <= history_in;
      end
   end

endmodule
